### src/gmrm_pkg.sv
package gmrm_pkg;

    localparam int CELL_W = 11;
    localparam int STAT_W = 3;
    localparam int PICK_W = 9;
    localparam int POS_W  = 6;

    typedef logic signed [CELL_W-1:0] t_cell;

    // wall list entry: row in the high half, column in the low half
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_wall_ent;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OPENED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_SAME     = 3'd1;
    localparam logic [STAT_W-1:0] ST_FIN_NOW  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FIN_OLD  = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_PICK = 3'd4;
    localparam logic [STAT_W-1:0] ST_READ     = 3'd5;

    // opcodes
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // cell contents
    localparam t_cell CV_WALL  = -11'sd1;
    localparam t_cell CV_OPEN  = 11'sd0;
    localparam t_cell CV_BLOCK = 11'sd7;
    localparam t_cell CV_ENTR  = 11'sd2;
    localparam t_cell CV_EXIT  = 11'sd4;

endpackage

### src/gmrm_ram.sv
module gmrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

### src/grid_maze_region_merge_top.sv
// Maze generator by region merging over a GRID_ROWS x GRID_COLS grid held in
// a single-port-read cell RAM and a wall-list RAM. After reset the block runs
// an init sweep over every cell (busy high) that writes the start labels and
// the wall list. A command is taken when start is high and busy is low; its
// result appears for exactly one cycle with o_strobe and cannot be held off,
// so the receiver must take it then. A bad pick or an already finished step
// is answered from the idle state; a read passes through the read state. An
// opening step reads the wall entry and its neighbors, sweeps every cell to
// relabel the merged region, then shifts the wall entries behind the pick
// down; the final conversion sweeps every cell. Each RAM has one read port,
// so the sweeps step through cells or list entries one at a time.
module grid_maze_region_merge_top #(
    parameter int GRID_ROWS = 33,
    parameter int GRID_COLS = 33
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [gmrm_pkg::PICK_W-1:0]       i_pick,
    input  logic [gmrm_pkg::POS_W-1:0]        i_read_row,
    input  logic [gmrm_pkg::POS_W-1:0]        i_read_col,
    output logic                              o_strobe,
    output logic [gmrm_pkg::STAT_W-1:0]       o_status,
    output logic [gmrm_pkg::PICK_W-1:0]       o_remaining,
    output logic [gmrm_pkg::POS_W-1:0]        o_wall_row,
    output logic [gmrm_pkg::POS_W-1:0]        o_wall_col,
    output logic signed [gmrm_pkg::CELL_W-1:0] o_cell_value
);

    import gmrm_pkg::*;

    localparam int CELLS    = GRID_ROWS * GRID_COLS;
    localparam int WALL_MAX = ((GRID_ROWS - 2) * (GRID_COLS - 2) + 1) / 2;
    localparam int AW       = $clog2(CELLS);
    localparam int WAW      = $clog2(WALL_MAX);
    localparam int WCW      = $clog2(WALL_MAX + 1);
    localparam int KW       = $clog2(CELLS + 1);
    localparam int WE_W     = 2 * POS_W;

    localparam logic [AW-1:0] ENTR_ADDR = AW'(GRID_COLS);
    localparam logic [AW-1:0] EXIT_ADDR = AW'((GRID_ROWS - 2) * GRID_COLS + GRID_COLS - 1);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_WALL  = 4'd3;
    localparam logic [3:0] S_A     = 4'd4;
    localparam logic [3:0] S_B     = 4'd5;
    localparam logic [3:0] S_REL   = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_E0    = 4'd8;
    localparam logic [3:0] S_E1    = 4'd9;
    localparam logic [3:0] S_CONV  = 4'd10;

    function automatic logic [AW-1:0] addr_of(input logic [POS_W-1:0] r,
                                              input logic [POS_W-1:0] c);
        return AW'(32'(r) * GRID_COLS + 32'(c));
    endfunction

    // RAM ports
    logic              cell_we;
    logic [AW-1:0]     cell_waddr;
    logic [CELL_W-1:0] cell_wdata;
    logic [AW-1:0]     cell_raddr;
    logic [CELL_W-1:0] cell_rdata;
    logic              wall_we;
    logic [WAW-1:0]    wall_waddr;
    t_wall_ent         wall_wdata;
    logic [WAW-1:0]    wall_raddr;
    logic [WE_W-1:0]   wall_rdata;
    t_wall_ent         wall_rd;
    t_cell             cell_rd;

    assign wall_rd = t_wall_ent'(wall_rdata);
    assign cell_rd = $signed(cell_rdata);

    gmrm_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    gmrm_ram #(.WIDTH(WE_W), .DEPTH(WALL_MAX)) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (wall_we),
        .i_waddr (wall_waddr),
        .i_wdata (wall_wdata),
        .i_raddr (wall_raddr),
        .o_rdata (wall_rdata)
    );

    // registers
    logic [3:0]        r_state,    n_state;
    logic [POS_W-1:0]  r_r,        n_r;
    logic [POS_W-1:0]  r_c,        n_c;
    t_cell             r_label,    n_label;
    t_cell             r_exit_lab, n_exit_lab;
    logic [WCW-1:0]    r_wcount,   n_wcount;
    logic              r_finished, n_finished;
    logic [KW-1:0]     r_k,        n_k;
    logic              r_sv,       n_sv;
    logic [KW-1:0]     r_wa,       n_wa;
    logic [PICK_W-1:0] r_pick,     n_pick;
    logic [POS_W-1:0]  r_wr,       n_wr;
    logic [POS_W-1:0]  r_wc,       n_wc;
    logic              r_vert,     n_vert;
    logic              r_opened,   n_opened;
    t_cell             r_a,        n_a;
    t_cell             r_b,        n_b;
    logic              r_rd_ok,    n_rd_ok;
    logic              r_strobe,   n_strobe;
    logic [STAT_W-1:0] r_status,   n_status;
    logic [PICK_W-1:0] r_rem,      n_rem;
    logic [POS_W-1:0]  r_orow,     n_orow;
    logic [POS_W-1:0]  r_ocol,     n_ocol;
    t_cell             r_oval,     n_oval;

    always_comb begin
        t_cell ival;
        logic  interior;

        n_state    = r_state;
        n_r        = r_r;
        n_c        = r_c;
        n_label    = r_label;
        n_exit_lab = r_exit_lab;
        n_wcount   = r_wcount;
        n_finished = r_finished;
        n_k        = r_k;
        n_sv       = r_sv;
        n_wa       = r_wa;
        n_pick     = r_pick;
        n_wr       = r_wr;
        n_wc       = r_wc;
        n_vert     = r_vert;
        n_opened   = r_opened;
        n_a        = r_a;
        n_b        = r_b;
        n_rd_ok    = r_rd_ok;
        n_strobe   = 1'b0;
        n_status   = r_status;
        n_rem      = r_rem;
        n_orow     = r_orow;
        n_ocol     = r_ocol;
        n_oval     = r_oval;

        cell_we    = 1'b0;
        cell_waddr = r_wa[AW-1:0];
        cell_wdata = '0;
        cell_raddr = r_k[AW-1:0];
        wall_we    = 1'b0;
        wall_waddr = r_wa[WAW-1:0];
        wall_wdata = t_wall_ent'(wall_rdata);
        wall_raddr = r_k[WAW-1:0];

        ival     = CV_WALL;
        interior = (r_r != '0) && (r_c != '0) &&
                   (32'(r_r) != GRID_ROWS - 1) && (32'(r_c) != GRID_COLS - 1);

        unique case (r_state)
            // column-major sweep writing start labels and the wall list
            S_INIT: begin
                if (r_r[0] && r_c[0]) begin
                    ival    = r_label;
                    n_label = CELL_W'(r_label + 11'sd1);
                    if (32'(r_r) == GRID_ROWS - 2 && 32'(r_c) == GRID_COLS - 2) begin
                        n_exit_lab = r_label;
                    end
                end else if (r_r == POS_W'(1) && r_c == '0) begin
                    ival = 11'sd1;
                end else if (32'(r_r) == GRID_ROWS - 2 && 32'(r_c) == GRID_COLS - 1) begin
                    ival = r_exit_lab;
                end
                cell_we    = 1'b1;
                cell_waddr = addr_of(r_r, r_c);
                cell_wdata = ival;
                if (interior && (r_r[0] ^ r_c[0]) && 32'(r_wcount) < WALL_MAX) begin
                    wall_we    = 1'b1;
                    wall_waddr = r_wcount[WAW-1:0];
                    wall_wdata = '{row: r_r, col: r_c};
                    n_wcount   = WCW'(r_wcount + 1'b1);
                end
                if (32'(r_r) == GRID_ROWS - 1) begin
                    n_r = '0;
                    n_c = POS_W'(r_c + 1'b1);
                    if (32'(r_c) == GRID_COLS - 1) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_r = POS_W'(r_r + 1'b1);
                end
            end

            S_IDLE: begin
                n_orow = '0;
                n_ocol = '0;
                n_oval = CV_OPEN;
                n_rem  = PICK_W'(r_wcount);
                if (start) begin
                    n_pick = i_pick;
                    if (i_opcode == OP_READ) begin
                        cell_raddr = addr_of(i_read_row, i_read_col);
                        n_rd_ok    = (32'(i_read_row) < GRID_ROWS) &&
                                     (32'(i_read_col) < GRID_COLS);
                        n_state    = S_READ;
                    end else if (r_wcount != '0) begin
                        if (32'(i_pick) >= 32'(r_wcount)) begin
                            n_status = ST_BAD_PICK;
                            n_strobe = 1'b1;
                        end else begin
                            wall_raddr = WAW'(i_pick);
                            n_state    = S_WALL;
                        end
                    end else if (r_finished) begin
                        n_status = ST_FIN_OLD;
                        n_strobe = 1'b1;
                    end else begin
                        cell_raddr = ENTR_ADDR;
                        n_state    = S_E0;
                    end
                end
            end

            S_READ: begin
                n_oval   = r_rd_ok ? cell_rd : CV_OPEN;
                n_status = ST_READ;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            // wall entry arrives: fetch first neighbor
            S_WALL: begin
                n_wr = wall_rd.row;
                n_wc = wall_rd.col;
                if (!wall_rd.row[0]) begin
                    n_vert     = 1'b1;
                    cell_raddr = addr_of(POS_W'(wall_rd.row - 1'b1), wall_rd.col);
                end else begin
                    n_vert     = 1'b0;
                    cell_raddr = addr_of(wall_rd.row, POS_W'(wall_rd.col - 1'b1));
                end
                n_state = S_A;
            end

            S_A: begin
                n_a = cell_rd;
                if (r_vert) begin
                    cell_raddr = addr_of(POS_W'(r_wr + 1'b1), r_wc);
                end else begin
                    cell_raddr = addr_of(r_wr, POS_W'(r_wc + 1'b1));
                end
                n_state = S_B;
            end

            S_B: begin
                if (cell_rd != r_a) begin
                    cell_we    = 1'b1;
                    cell_waddr = addr_of(r_wr, r_wc);
                    cell_wdata = r_a;
                    n_b        = cell_rd;
                    n_opened   = 1'b1;
                    n_k        = '0;
                    n_sv       = 1'b0;
                    n_state    = S_REL;
                end else if (r_vert) begin
                    // same region vertically: try the left/right pair
                    n_vert     = 1'b0;
                    cell_raddr = addr_of(r_wr, POS_W'(r_wc - 1'b1));
                    n_state    = S_A;
                end else begin
                    n_opened = 1'b0;
                    n_k      = KW'(32'(r_pick) + 1);
                    n_sv     = 1'b0;
                    n_state  = S_SHIFT;
                end
            end

            // read k, write back k-1 with the merged label
            S_REL: begin
                if (r_sv && cell_rd == r_b) begin
                    cell_we    = 1'b1;
                    cell_wdata = r_a;
                end
                if (32'(r_k) < CELLS) begin
                    n_wa = r_k;
                    n_sv = 1'b1;
                    n_k  = KW'(r_k + 1'b1);
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_k     = KW'(32'(r_pick) + 1);
                        n_state = S_SHIFT;
                    end
                end
            end

            // move list entries after the pick down by one
            S_SHIFT: begin
                if (r_sv) begin
                    wall_we = 1'b1;
                end
                if (32'(r_k) < 32'(r_wcount)) begin
                    n_wa = KW'(r_k - 1'b1);
                    n_sv = 1'b1;
                    n_k  = KW'(r_k + 1'b1);
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_wcount = WCW'(r_wcount - 1'b1);
                        n_rem    = PICK_W'(r_wcount - 1'b1);
                        n_orow   = r_wr;
                        n_ocol   = r_wc;
                        n_status = r_opened ? ST_OPENED : ST_SAME;
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end

            S_E0: begin
                n_a        = cell_rd;
                cell_raddr = ENTR_ADDR + 1'b1;
                n_state    = S_E1;
            end

            S_E1: begin
                if (cell_rd == r_a) begin
                    n_k     = '0;
                    n_sv    = 1'b0;
                    n_state = S_CONV;
                end else begin
                    n_status = ST_FIN_OLD;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            // final conversion sweep
            S_CONV: begin
                if (r_sv) begin
                    cell_we = 1'b1;
                    if (r_wa[AW-1:0] == ENTR_ADDR) begin
                        cell_wdata = CV_ENTR;
                    end else if (r_wa[AW-1:0] == EXIT_ADDR) begin
                        cell_wdata = CV_EXIT;
                    end else begin
                        cell_wdata = (cell_rd > 0) ? CV_OPEN : CV_BLOCK;
                    end
                end
                if (32'(r_k) < CELLS) begin
                    n_wa = r_k;
                    n_sv = 1'b1;
                    n_k  = KW'(r_k + 1'b1);
                end else begin
                    n_sv = 1'b0;
                    if (!r_sv) begin
                        n_finished = 1'b1;
                        n_status   = ST_FIN_NOW;
                        n_strobe   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_r        <= '0;
            r_c        <= '0;
            r_label    <= 11'sd1;
            r_exit_lab <= CV_WALL;
            r_wcount   <= '0;
            r_finished <= 1'b0;
            r_k        <= '0;
            r_sv       <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_r        <= n_r;
            r_c        <= n_c;
            r_label    <= n_label;
            r_exit_lab <= n_exit_lab;
            r_wcount   <= n_wcount;
            r_finished <= n_finished;
            r_k        <= n_k;
            r_sv       <= n_sv;
            r_strobe   <= n_strobe;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_wa     <= n_wa;
        r_pick   <= n_pick;
        r_wr     <= n_wr;
        r_wc     <= n_wc;
        r_vert   <= n_vert;
        r_opened <= n_opened;
        r_a      <= n_a;
        r_b      <= n_b;
        r_rd_ok  <= n_rd_ok;
        r_status <= n_status;
        r_rem    <= n_rem;
        r_orow   <= n_orow;
        r_ocol   <= n_ocol;
        r_oval   <= n_oval;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_remaining  = r_rem;
    assign o_wall_row   = r_orow;
    assign o_wall_col   = r_ocol;
    assign o_cell_value = r_oval;

endmodule

### dv/tb_grid_maze_region_merge_top.sv
module tb_grid_maze_region_merge_top;
    import gmrm_pkg::*;

    localparam int ROWS     = 33;
    localparam int COLS     = 33;
    localparam int NCELL    = ROWS * COLS;
    localparam int NWALL    = ((ROWS - 2) * (COLS - 2) + 1) / 2;
    localparam int N_RAND   = 370;
    localparam int IDLE_MAX = 8000;

    typedef struct packed {
        logic              op;
        logic [PICK_W-1:0] pick;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PICK_W-1:0] remaining;
        logic [POS_W-1:0]  wrow;
        logic [POS_W-1:0]  wcol;
        t_cell             value;
    } t_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_opcode;
    logic [PICK_W-1:0] i_pick;
    logic [POS_W-1:0]  i_read_row;
    logic [POS_W-1:0]  i_read_col;
    logic              o_strobe;
    logic [STAT_W-1:0] o_status;
    logic [PICK_W-1:0] o_remaining;
    logic [POS_W-1:0]  o_wall_row;
    logic [POS_W-1:0]  o_wall_col;
    t_cell             o_cell_value;

    grid_maze_region_merge_top #(.GRID_ROWS(ROWS), .GRID_COLS(COLS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_pick(i_pick), .i_read_row(i_read_row),
        .i_read_col(i_read_col), .o_strobe(o_strobe), .o_status(o_status),
        .o_remaining(o_remaining), .o_wall_row(o_wall_row),
        .o_wall_col(o_wall_col), .o_cell_value(o_cell_value)
    );

    // maze predictor state
    t_cell     maze[NCELL];
    t_wall_ent walls[$];
    bit        maze_done;

    t_cmd cmd_q[$];
    t_res expect_q[$];
    int   fails;
    int   idle_cycles;
    bit   stim_done;
    bit   drain_hold;   // sender waits for an empty expectation queue
    bit   beat_taken;   // the driven beat was accepted at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int cidx(int r, int c);
        return r * COLS + c;
    endfunction

    // queue appends
    function automatic void add_wall(t_wall_ent w);
        walls = {walls, w};
    endfunction

    function automatic void send_cmd(t_cmd cmd);
        cmd_q = {cmd_q, cmd};
    endfunction

    function automatic void add_expect(t_res res);
        expect_q = {expect_q, res};
    endfunction

    function automatic void maze_reset();
        int lbl;
        lbl = 1;
        walls.delete();
        foreach (maze[k]) maze[k] = CV_WALL;
        for (int c = 0; c < COLS; c++) begin
            for (int r = 0; r < ROWS; r++) begin
                if ((c % 2) && (r % 2)) begin
                    maze[cidx(r, c)] = t_cell'(lbl);
                    lbl++;
                end
                if (r != 0 && c != 0 && r != ROWS - 1 && c != COLS - 1 && ((r + c) % 2))
                    add_wall('{row: r[POS_W-1:0], col: c[POS_W-1:0]});
            end
        end
        maze[cidx(1, 0)] = maze[cidx(1, 1)];
        maze[cidx(ROWS - 2, COLS - 1)] = maze[cidx(ROWS - 2, COLS - 2)];
        maze_done = 1'b0;
    endfunction

    // open wall (r,c) if the two given neighbors differ
    function automatic bit join_regions(int r, int c, int r1, int c1, int r2, int c2);
        t_cell a, b;
        a = maze[cidx(r1, c1)];
        b = maze[cidx(r2, c2)];
        if (a == b) return 1'b0;
        maze[cidx(r, c)] = a;
        foreach (maze[k]) if (maze[k] == b) maze[k] = a;
        return 1'b1;
    endfunction

    function automatic t_res maze_apply(t_cmd cmd);
        t_res res;
        bit   opened;
        int   wr, wc;
        res = '0;
        if (cmd.op == OP_READ) begin
            res.status = ST_READ;
            if (cmd.row < ROWS && cmd.col < COLS) res.value = maze[cidx(cmd.row, cmd.col)];
        end else if (walls.size() > 0) begin
            if (cmd.pick >= walls.size()) begin
                res.status = ST_BAD_PICK;
            end else begin
                wr = walls[cmd.pick].row;
                wc = walls[cmd.pick].col;
                res.wrow = wr[POS_W-1:0];
                res.wcol = wc[POS_W-1:0];
                opened = 1'b0;
                if (wr % 2 == 0) opened = join_regions(wr, wc, wr - 1, wc, wr + 1, wc);
                if (!opened) opened = join_regions(wr, wc, wr, wc - 1, wr, wc + 1);
                walls.delete(cmd.pick);
                res.status = opened ? ST_OPENED : ST_SAME;
            end
        end else if (!maze_done && maze[cidx(1, 0)] == maze[cidx(1, 1)]) begin
            foreach (maze[k]) maze[k] = (maze[k] > 0) ? CV_OPEN : CV_BLOCK;
            maze[cidx(1, 0)] = CV_ENTR;
            maze[cidx(ROWS - 2, COLS - 1)] = CV_EXIT;
            maze_done = 1'b1;
            res.status = ST_FIN_NOW;
        end else begin
            res.status = ST_FIN_OLD;
        end
        res.remaining = PICK_W'(walls.size());
        return res;
    endfunction

    function automatic t_cmd mk_cmd(logic op, int pick, int r, int c);
        t_cmd cmd;
        cmd.op   = op;
        cmd.pick = pick[PICK_W-1:0];
        cmd.row  = r[POS_W-1:0];
        cmd.col  = c[POS_W-1:0];
        return cmd;
    endfunction

    function automatic t_cmd rand_read();
        // mostly in-grid, sometimes out of range, occasionally full-range bits
        if ($urandom_range(0, 9) == 0)
            return mk_cmd(OP_READ, $urandom, $urandom_range(0, 63), $urandom_range(0, 63));
        return mk_cmd(OP_READ, $urandom, $urandom_range(0, ROWS), $urandom_range(0, COLS));
    endfunction

    // driver: bursts and gaps, beat taken when start && !busy
    int burst_left, gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !beat_taken) begin
            // beat still pending, hold
        end else if (drain_hold && expect_q.size() != 0) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
        end else if (cmd_q.size() > 0) begin
            t_cmd cmd;
            cmd = cmd_q.pop_front();
            start      <= 1'b1;
            i_opcode   <= cmd.op;
            i_pick     <= cmd.pick;
            i_read_row <= cmd.row;
            i_read_col <= cmd.col;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 8);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            start <= 1'b0;
        end
    end

    // accept tracking at the rising edge
    always @(posedge i_clk) begin
        beat_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            add_expect(maze_apply({i_opcode, i_pick, i_read_row, i_read_col}));
            idle_cycles <= 0;
        end else if (i_rst_n && o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expect_q.size() == 0) begin
                $error("unexpected result beat, status %0d", o_status);
                fails++;
            end else begin
                t_res exp_r;
                exp_r = expect_q.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_status); fails++;
                end
                if (o_remaining !== exp_r.remaining) begin
                    $error("remaining exp %0d got %0d", exp_r.remaining, o_remaining); fails++;
                end
                if (o_wall_row !== exp_r.wrow) begin
                    $error("wall_row exp %0d got %0d", exp_r.wrow, o_wall_row); fails++;
                end
                if (o_wall_col !== exp_r.wcol) begin
                    $error("wall_col exp %0d got %0d", exp_r.wcol, o_wall_col); fails++;
                end
                if (o_cell_value !== exp_r.value) begin
                    $error("cell_value exp %0d got %0d", exp_r.value, o_cell_value); fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (idle_cycles > IDLE_MAX) begin
            $display("grid_maze_region_merge_top verification failed");
            $finish;
        end
    end

    initial begin
        int left;
        start = 1'b0; i_opcode = OP_STEP; i_pick = '0; i_read_row = '0; i_read_col = '0;
        i_rst_n = 1'b0; fails = 0; idle_cycles = 0; stim_done = 0; drain_hold = 0;
        burst_left = 0; gap_left = 0; beat_taken = 1'b0;
        maze_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: reads of corners, entrance/exit, out of range, picks
        send_cmd(mk_cmd(OP_READ, 0, 0, 0));
        send_cmd(mk_cmd(OP_READ, 0, 1, 0));
        send_cmd(mk_cmd(OP_READ, 0, 1, 1));
        send_cmd(mk_cmd(OP_READ, 0, ROWS - 2, COLS - 1));
        send_cmd(mk_cmd(OP_READ, 511, ROWS - 1, COLS - 1));
        send_cmd(mk_cmd(OP_READ, 0, 63, 5));
        send_cmd(mk_cmd(OP_READ, 0, 5, 63));
        send_cmd(mk_cmd(OP_READ, 0, ROWS, 1));
        send_cmd(mk_cmd(OP_STEP, 511, 63, 63));
        send_cmd(mk_cmd(OP_STEP, NWALL, 0, 0));
        send_cmd(mk_cmd(OP_STEP, NWALL - 1, 0, 0));
        send_cmd(mk_cmd(OP_STEP, 0, 0, 0));
        send_cmd(mk_cmd(OP_STEP, 0, 0, 0));
        send_cmd(mk_cmd(OP_STEP, 1, 0, 0));
        send_cmd(mk_cmd(OP_READ, 0, 1, 2));
        send_cmd(mk_cmd(OP_STEP, NWALL - 4, 0, 0));
        wait (cmd_q.size() == 0);

        // pressure: let everything drain once
        drain_hold = 1;
        wait (expect_q.size() == 0 && !start);
        drain_hold = 0;

        // random: mostly valid picks into the shrinking list, then finish
        left = NWALL - 4;
        for (int n = 0; n < N_RAND; n++) begin
            case ($urandom_range(0, 9))
                0, 1: send_cmd(rand_read());
                2: send_cmd(mk_cmd(OP_STEP, $urandom_range(left, 511), $urandom, $urandom));
                default: begin
                    if (left > 0) begin
                        send_cmd(mk_cmd(OP_STEP, $urandom_range(0, left - 1),
                                        $urandom, $urandom));
                        left--;
                    end else begin
                        send_cmd(mk_cmd(OP_STEP, $urandom, $urandom, $urandom));
                    end
                end
            endcase
            if (cmd_q.size() > 8) wait (cmd_q.size() <= 8);
        end
        // drain all remaining walls, convert, step again, then read back
        while (left > 0) begin
            send_cmd(mk_cmd(OP_STEP, $urandom_range(0, left - 1), 0, 0));
            left--;
            if (cmd_q.size() > 8) wait (cmd_q.size() <= 8);
        end
        send_cmd(mk_cmd(OP_STEP, 0, 0, 0));
        send_cmd(mk_cmd(OP_STEP, 511, 0, 0));
        send_cmd(mk_cmd(OP_READ, 0, 1, 0));
        send_cmd(mk_cmd(OP_READ, 0, ROWS - 2, COLS - 1));
        for (int n = 0; n < 20; n++) send_cmd(rand_read());

        wait (cmd_q.size() == 0);
        @(posedge i_clk);
        wait (expect_q.size() == 0 && !start);
        repeat (20) @(posedge i_clk);
        if (fails == 0) begin
            $display("grid_maze_region_merge_top verification clean");
        end else begin
            $display("grid_maze_region_merge_top verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/gmrm_pkg.sv
src/gmrm_ram.sv
src/grid_maze_region_merge_top.sv
dv/tb_grid_maze_region_merge_top.sv
